// ===== hdl/drme_pkg.sv =====
// shared constants and codes for the decimating running-mean estimator
`default_nettype none
package drme_pkg;

  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF   = 32;

  // width of the shared serial divider dividend
  localparam int DIV_W     = 64;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] KIND_MEASURE  = 2'd0;
  localparam logic [1:0] KIND_RECORD   = 2'd1;
  localparam logic [1:0] KIND_ESTIMATE = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  localparam logic [30:0] ERROR_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] RATIO_MAX = 16'h7FFF;
  localparam logic [15:0] RATIO_MIN = 16'h8000;
  localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ===== hdl/drme_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module drme_div
  import drme_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [31:0]      divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic [DIV_W-1:0]     dvd_q;
  logic [31:0]          dsr_q;
  logic [31:0]          rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [32:0]          rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], ge};
      rem_q <= ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

// ===== hdl/drme_hist_mem.sv =====
// history memory, one write port and one registered read port
`default_nettype none
module drme_hist_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/decimating_running_mean_estimator_core.sv =====
// measure, clear and a record that stores nothing: handled in the idle state, accepted back to back
// record that stores a point: the mean comes from the shared serial divider, then is written to the history
// record on a full history: compaction that keeps every second entry and doubles the record interval
// estimate: mean divide, scan of entries fill/3 to fill-1, ratio divide (scan and ratio skipped if empty)
// one result per estimate, held in an output register until taken
// reset is asynchronous: statistics cleared, history contents undefined until written
`default_nettype none
module decimating_running_mean_estimator_core
  import drme_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         kind_i,
  input  wire logic signed [31:0]                 sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]           mean_o,
  output logic [30:0]                             error_bar_o,
  output logic signed [15:0]                      drift_ratio_o,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0]      fill_o,
  output logic [31:0]                             record_interval_o
);

  localparam int AW      = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int HALF    = HISTORY_DEPTH / 2;
  localparam int VW      = VALUE_WIDTH;
  localparam int DIV3_SH = 2 * ((FILL_W + 2) / 2);
  localparam longint DIV3_MUL_L = ((64'sd1 <<< DIV3_SH) + 2) / 3;
  localparam logic [FILL_W+DIV3_SH-1:0] DIV3_MUL = (FILL_W+DIV3_SH)'(DIV3_MUL_L);
  localparam logic [63:0] MEAN_LIM = 64'd1 << (VW - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_REC_DIV  = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_EST_DIV  = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SCAN_END = 3'd5;
  localparam logic [2:0] S_RAT_DIV  = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  function automatic logic [VW-1:0] sat_mean(input logic neg, input logic [63:0] q);
    logic [VW-1:0] r;
    if (neg) begin
      r = (q >= MEAN_LIM) ? {1'b1, {(VW-1){1'b0}}} : VW'(64'd0 - q);
    end else begin
      r = (q > MEAN_LIM - 64'd1) ? {1'b0, {(VW-1){1'b1}}} : VW'(q);
    end
    return r;
  endfunction

  logic [2:0]            state_q, state_d;
  logic signed [63:0]    acc_q, acc_d;
  logic [31:0]           norm_q, norm_d;
  logic [31:0]           intv_q, intv_d;
  logic [31:0]           calls_q, calls_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [30:0]           err_q, err_d;
  logic [15:0]           ratio_q, ratio_d;
  logic                  neg_q, neg_d;
  logic [VW-1:0]         mean_q, mean_d;
  // scan
  logic [FILL_W-1:0]     sc_addr_q, sc_addr_d;
  logic                  sc_v_q, sc_v_d;
  logic [FILL_W-1:0]     sc_idx_q, sc_idx_d;
  logic                  first_q, first_d;
  logic signed [VW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [FILL_W-1:0]     lo_idx_q, lo_idx_d, hi_idx_q, hi_idx_d;
  // compaction
  logic [AW-1:0]         cmp_i_q, cmp_i_d, cmp_wi_q, cmp_wi_d;
  logic                  cmp_iss_q, cmp_iss_d, cmp_wv_q, cmp_wv_d;
  // output register
  logic                  ov_q, ov_d;
  logic [VW-1:0]         o_mean_q, o_mean_d;
  logic [30:0]           o_err_q, o_err_d;
  logic [15:0]           o_ratio_q, o_ratio_d;
  logic [FILL_W-1:0]     o_fill_q, o_fill_d;
  logic [31:0]           o_intv_q, o_intv_d;

  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_dvd, div_q;
  logic [31:0]           div_dsr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [VW-1:0]         mem_wdata, mem_rdata;

  logic                  accept;
  logic signed [63:0]    s64, sum;
  logic [63:0]           acc_mag;
  logic [31:0]           calls_inc;
  logic [FILL_W+DIV3_SH-1:0] prod3;
  logic [FILL_W-1:0]     third;
  logic [VW:0]           diff;
  logic [FILL_W:0]       idx_diff, idx_mag;
  logic [FILL_W+1:0]     fill3;
  logic [VW-1:0]         mean_new;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign s64       = 64'(sample_i);
  assign sum       = acc_q + s64;
  assign acc_mag   = acc_q[63] ? 64'd0 - acc_q : acc_q;
  assign calls_inc = (calls_q == U32_MAX) ? calls_q : calls_q + 32'd1;
  assign prod3     = (FILL_W+DIV3_SH)'(fill_q) * DIV3_MUL;
  assign third     = FILL_W'(prod3 >> DIV3_SH);
  assign diff      = {hi_q[VW-1], hi_q} - {lo_q[VW-1], lo_q};
  assign idx_diff  = {1'b0, hi_idx_q} - {1'b0, lo_idx_q};
  assign idx_mag   = idx_diff[FILL_W] ? (FILL_W+1)'(0) - idx_diff : idx_diff;
  assign fill3     = ((FILL_W+2)'(fill_q) << 1) + (FILL_W+2)'(fill_q);
  assign mean_new  = sat_mean(neg_q, div_q);

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    norm_d    = norm_q;
    intv_d    = intv_q;
    calls_d   = calls_q;
    fill_d    = fill_q;
    err_d     = err_q;
    ratio_d   = ratio_q;
    neg_d     = neg_q;
    mean_d    = mean_q;
    sc_addr_d = sc_addr_q;
    sc_v_d    = 1'b0;
    sc_idx_d  = sc_idx_q;
    first_d   = first_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    lo_idx_d  = lo_idx_q;
    hi_idx_d  = hi_idx_q;
    cmp_i_d   = cmp_i_q;
    cmp_wi_d  = cmp_wi_q;
    cmp_iss_d = cmp_iss_q;
    cmp_wv_d  = 1'b0;
    ov_d      = ov_q && out_stall_i;
    o_mean_d  = o_mean_q;
    o_err_d   = o_err_q;
    o_ratio_d = o_ratio_q;
    o_fill_d  = o_fill_q;
    o_intv_d  = o_intv_q;
    div_start = 1'b0;
    div_dvd   = acc_mag;
    div_dsr   = norm_q;
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    mem_wdata = mean_new;
    mem_raddr = sc_addr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_MEASURE: begin
              if ((acc_q[63] == s64[63]) && (sum[63] != acc_q[63])) begin
                acc_d = acc_q[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
              end else begin
                acc_d = sum;
              end
              if (norm_q != U32_MAX) begin
                norm_d = norm_q + 32'd1;
              end
            end
            KIND_RECORD: begin
              if (fill_q >= FILL_W'(HISTORY_DEPTH)) begin
                cmp_i_d   = '0;
                cmp_iss_d = 1'b1;
                state_d   = S_CMP;
              end else begin
                calls_d = calls_inc;
                if (calls_inc >= intv_q) begin
                  div_start = 1'b1;
                  neg_d     = acc_q[63];
                  state_d   = S_REC_DIV;
                end
              end
            end
            KIND_ESTIMATE: begin
              div_start = 1'b1;
              neg_d     = acc_q[63];
              state_d   = S_EST_DIV;
            end
            KIND_CLEAR: begin
              acc_d   = '0;
              norm_d  = 32'd1;
              intv_d  = 32'd1;
              calls_d = '0;
              fill_d  = '0;
              err_d   = '0;
              ratio_d = RATIO_MAX;
            end
            default: ;
          endcase
        end
      end
      S_REC_DIV: begin
        if (div_done) begin
          mem_we  = 1'b1;
          fill_d  = fill_q + 1'b1;
          calls_d = '0;
          state_d = S_IDLE;
        end
      end
      S_CMP: begin
        // read entry 2i, write it back to entry i in the next cycle
        mem_raddr = AW'({cmp_i_q, 1'b0});
        mem_waddr = cmp_wi_q;
        mem_wdata = mem_rdata;
        mem_we    = cmp_wv_q;
        if (cmp_iss_q) begin
          cmp_wv_d = 1'b1;
          cmp_wi_d = cmp_i_q;
          if (cmp_i_q == AW'(HALF - 1)) begin
            cmp_iss_d = 1'b0;
          end else begin
            cmp_i_d = cmp_i_q + 1'b1;
          end
        end else if (cmp_wv_q) begin
          fill_d  = FILL_W'(HALF);
          intv_d  = intv_q[31] ? U32_MAX : {intv_q[30:0], 1'b0};
          state_d = S_IDLE;
        end
      end
      S_EST_DIV: begin
        if (div_done) begin
          mean_d = mean_new;
          if (fill_q == '0) begin
            state_d = S_OUT;
          end else begin
            sc_addr_d = third;
            first_d   = 1'b1;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sc_addr_q < fill_q) begin
          sc_v_d    = 1'b1;
          sc_idx_d  = sc_addr_q;
          sc_addr_d = sc_addr_q + 1'b1;
        end else if (!sc_v_q) begin
          state_d = S_SCAN_END;
        end
        if (sc_v_q) begin
          first_d = 1'b0;
          // oldest extreme wins on ties
          if (first_q || ($signed(mem_rdata) < lo_q)) begin
            lo_d     = mem_rdata;
            lo_idx_d = sc_idx_q;
          end
          if (first_q || ($signed(mem_rdata) > hi_q)) begin
            hi_d     = mem_rdata;
            hi_idx_d = sc_idx_q;
          end
        end
      end
      S_SCAN_END: begin
        err_d     = (64'(diff[VW:1]) > 64'(ERROR_MAX)) ? ERROR_MAX : 31'(diff[VW:1]);
        neg_d     = idx_diff[FILL_W];
        div_start = 1'b1;
        div_dvd   = 64'(idx_mag) << 16;
        div_dsr   = 32'(fill3);
        state_d   = S_RAT_DIV;
      end
      S_RAT_DIV: begin
        if (div_done) begin
          if (neg_q) begin
            ratio_d = (div_q >= 64'd32768) ? RATIO_MIN : 16'(64'd0 - div_q);
          end else begin
            ratio_d = (div_q > 64'd32767) ? RATIO_MAX : 16'(div_q);
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d      = 1'b1;
          o_mean_d  = mean_q;
          o_err_d   = err_q;
          o_ratio_d = ratio_q;
          o_fill_d  = fill_q;
          o_intv_d  = intv_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      acc_q     <= '0;
      norm_q    <= 32'd1;
      intv_q    <= 32'd1;
      calls_q   <= '0;
      fill_q    <= '0;
      err_q     <= '0;
      ratio_q   <= RATIO_MAX;
      sc_v_q    <= 1'b0;
      cmp_iss_q <= 1'b0;
      cmp_wv_q  <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      norm_q    <= norm_d;
      intv_q    <= intv_d;
      calls_q   <= calls_d;
      fill_q    <= fill_d;
      err_q     <= err_d;
      ratio_q   <= ratio_d;
      sc_v_q    <= sc_v_d;
      cmp_iss_q <= cmp_iss_d;
      cmp_wv_q  <= cmp_wv_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q     <= neg_d;
    mean_q    <= mean_d;
    sc_addr_q <= sc_addr_d;
    sc_idx_q  <= sc_idx_d;
    first_q   <= first_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    lo_idx_q  <= lo_idx_d;
    hi_idx_q  <= hi_idx_d;
    cmp_i_q   <= cmp_i_d;
    cmp_wi_q  <= cmp_wi_d;
    o_mean_q  <= o_mean_d;
    o_err_q   <= o_err_d;
    o_ratio_q <= o_ratio_d;
    o_fill_q  <= o_fill_d;
    o_intv_q  <= o_intv_d;
  end

  drme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  drme_hist_mem #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o       = ov_q;
  assign mean_o            = o_mean_q;
  assign error_bar_o       = o_err_q;
  assign drift_ratio_o     = o_ratio_q;
  assign fill_o            = o_fill_q;
  assign record_interval_o = o_intv_q;

endmodule
`default_nettype wire

// ===== hdl/drme_checker.sv =====
// port-level checks for the estimator core and their bind
`default_nettype none
module drme_checker #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int VALUE_WIDTH   = 32
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [VALUE_WIDTH-1:0]        mean_o,
  input wire logic [$clog2(HISTORY_DEPTH+1)-1:0] fill_o,
  input wire logic [31:0]                   record_interval_o
);

  // a held transaction keeps its mean and fill
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_o) && $stable(fill_o))
    else $error("result changed while stalled");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_o <= ($clog2(HISTORY_DEPTH+1))'(HISTORY_DEPTH))
    else $error("fill beyond history depth");

  a_intv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> record_interval_o != 32'd0)
    else $error("record interval is zero");

  // a fresh result comes only out of a busy estimate
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a busy phase");

endmodule

bind decimating_running_mean_estimator_core drme_checker #(
  .HISTORY_DEPTH (HISTORY_DEPTH),
  .VALUE_WIDTH   (VALUE_WIDTH)
) u_drme_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .mean_o            (mean_o),
  .fill_o            (fill_o),
  .record_interval_o (record_interval_o)
);
`default_nettype wire

// ===== sim/tb_decimating_running_mean_estimator_core.sv =====
// randomized self-checking testbench for the decimating running-mean estimator core
`default_nettype none
module tb_decimating_running_mean_estimator_core;
  import drme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = HISTORY_DEPTH_DEF;

  typedef struct {
    logic signed [31:0] mean;
    logic [30:0]        error_bar;
    logic signed [15:0] drift_ratio;
    logic [10:0]        fill;
    logic [31:0]        record_interval;
  } estimate_t;

  class mean_scoreboard;
    longint      acc;
    int unsigned norm;
    int unsigned interval;
    int unsigned calls;
    int unsigned fill;
    longint      hist [DEPTH];
    int unsigned err_held;
    int          ratio_held;
    estimate_t   pending [$];
    int          mismatches;

    function void restart();
      acc        = 0;
      norm       = 1;
      interval   = 1;
      calls      = 0;
      fill       = 0;
      err_held   = 0;
      ratio_held = 32767;
    endfunction

    function longint mean_now();
      logic [63:0] mag;
      logic [63:0] q;
      mag = (acc < 0) ? 64'(-acc) : 64'(acc);
      q = mag / {32'd0, norm};
      if (acc < 0) begin
        if (q >= 64'h8000_0000) return -64'sh8000_0000;
        return -longint'(q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return longint'(q);
    endfunction

    function void scan_history();
      int unsigned lo_idx, hi_idx;
      longint lo, hi, r;
      longint unsigned diff;
      if (fill == 0) return;
      lo_idx = fill / 3;
      hi_idx = lo_idx;
      lo = hist[lo_idx];
      hi = lo;
      for (int unsigned i = fill / 3 + 1; i < fill; i++) begin
        if (hist[i] < lo) begin
          lo = hist[i];
          lo_idx = i;
        end
        if (hist[i] > hi) begin
          hi = hist[i];
          hi_idx = i;
        end
      end
      diff = longint'(hi - lo) / 2;
      err_held = (diff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(diff);
      r = ((longint'(hi_idx) - longint'(lo_idx)) * 65536) / (longint'(fill) * 3);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      ratio_held = int'(r);
    endfunction

    // called once per accepted input transaction
    function void note_input(logic [1:0] kind, logic signed [31:0] sample);
      longint s;
      estimate_t e;
      case (kind)
        KIND_MEASURE: begin
          s = longint'(sample);
          if (s > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - s) acc = 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (s < 0 && acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - s)
            acc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
          else acc += s;
          if (norm != U32_MAX) norm++;
        end
        KIND_RECORD: begin
          if (fill >= DEPTH) begin
            // full history: keep every second point, no call counted
            for (int i = 0; i < DEPTH / 2; i++) hist[i] = hist[2 * i];
            fill = DEPTH / 2;
            interval = (interval >= 32'h8000_0000) ? U32_MAX : interval * 2;
          end else begin
            if (calls != U32_MAX) calls++;
            if (calls >= interval) begin
              hist[fill] = mean_now();
              fill++;
              calls = 0;
            end
          end
        end
        KIND_ESTIMATE: begin
          e.mean = 32'(mean_now());
          scan_history();
          e.error_bar       = err_held[30:0];
          e.drift_ratio     = ratio_held[15:0];
          e.fill            = fill[10:0];
          e.record_interval = interval;
          pending = {pending, e};
        end
        default: restart();
      endcase
    endfunction

    function void check_result(estimate_t act);
      estimate_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected estimate result, mean %0d", $realtime, act.mean);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.mean !== exp_r.mean) begin
        $display("%0t: mean expected %0d actual %0d", $realtime, exp_r.mean, act.mean);
        mismatches++;
      end
      if (act.error_bar !== exp_r.error_bar) begin
        $display("%0t: error_bar expected %0d actual %0d", $realtime,
                 exp_r.error_bar, act.error_bar);
        mismatches++;
      end
      if (act.drift_ratio !== exp_r.drift_ratio) begin
        $display("%0t: drift_ratio expected %0d actual %0d", $realtime,
                 exp_r.drift_ratio, act.drift_ratio);
        mismatches++;
      end
      if (act.fill !== exp_r.fill) begin
        $display("%0t: fill expected %0d actual %0d", $realtime, exp_r.fill, act.fill);
        mismatches++;
      end
      if (act.record_interval !== exp_r.record_interval) begin
        $display("%0t: record_interval expected %0d actual %0d", $realtime,
                 exp_r.record_interval, act.record_interval);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         kind_i = KIND_MEASURE;
  logic signed [31:0] sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] mean_o;
  logic [30:0]        error_bar_o;
  logic signed [15:0] drift_ratio_o;
  logic [10:0]        fill_o;
  logic [31:0]        record_interval_o;

  mean_scoreboard sb;
  int  idle_pct = 9;
  bit  hold_req = 1'b0;

  decimating_running_mean_estimator_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .sample_i,
    .out_valid_o, .out_stall_i, .mean_o, .error_bar_o, .drift_ratio_o,
    .fill_o, .record_interval_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(logic [1:0] kind, logic signed [31:0] sample);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    sample_i   <= sample;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(kind, sample);
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'(int'($urandom_range(4095)) - 2048);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 62) send_item(KIND_MEASURE, pick_sample());
      else if (pick < 85) send_item(KIND_RECORD, $urandom);
      else if (pick < 97) send_item(KIND_ESTIMATE, $urandom);
      else send_item(KIND_CLEAR, $urandom);
    end
  endtask

  // result side: check, then pick the stall for the next cycle
  initial begin
    estimate_t act;
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        act.mean            = mean_o;
        act.error_bar       = error_bar_o;
        act.drift_ratio     = drift_ratio_o;
        act.fill            = fill_o;
        act.record_interval = record_interval_o;
        sb.check_result(act);
      end
      if (hold_req && hold_left == 0) begin
        hold_left = 3000;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  initial begin
    sb = new();
    sb.restart();
    sb.mismatches = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty history, extremes, ties, clear
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_MEASURE, 32'sh7FFF_FFFF);
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_MEASURE, 32'sh8000_0000);
    send_item(KIND_MEASURE, 32'sh8000_0000);
    send_item(KIND_RECORD, 32'sd0);
    send_item(KIND_RECORD, 32'sd0);
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_MEASURE, 32'sh7FFF_FFFF);
    send_item(KIND_MEASURE, 32'sh7FFF_FFFF);
    send_item(KIND_RECORD, 32'sd0);
    send_item(KIND_MEASURE, 32'sd0);
    send_item(KIND_RECORD, 32'sd0);
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_CLEAR, 32'sd0);
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_MEASURE, -32'sd1);
    send_item(KIND_RECORD, 32'sd0);
    send_item(KIND_ESTIMATE, 32'sd0);
    send_item(KIND_CLEAR, 32'sd0);

    // receiver holds off while estimates and measures keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item((i % 4 == 0) ? KIND_ESTIMATE : KIND_MEASURE, pick_sample());

    send_random(100);

    // stretch with no idling on either side
    idle_pct = 0;
    send_random(60);
    idle_pct = 9;

    // fill the history to the top, then compact once
    send_item(KIND_CLEAR, 32'sd0);
    for (int i = 0; i < DEPTH + 2; i++) begin
      if (i % 32 == 0) send_item(KIND_MEASURE, pick_sample());
      send_item(KIND_RECORD, 32'sd0);
      if (i % 256 == 0) send_item(KIND_ESTIMATE, 32'sd0);
    end
    send_item(KIND_ESTIMATE, 32'sd0);

    send_random(40);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/drme_pkg.sv
hdl/drme_div.sv
hdl/drme_hist_mem.sv
hdl/decimating_running_mean_estimator_core.sv
hdl/drme_checker.sv
sim/tb_decimating_running_mean_estimator_core.sv
